// ----- hw/rtl/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes of the double-ended queue: request codes, result
// status codes, datapath operations and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned ReqW  = 3;
  localparam int unsigned StatW = 2;

  // request codes carried on the input channel
  typedef enum logic [ReqW-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_QUERY      = 3'd4
  } req_type_e;

  // result status codes
  typedef enum logic [StatW-1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // operation the datapath applies to the ring
  typedef enum logic [2:0] {
    OP_NONE       = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4
  } op_e;

  // commands from the controller
  typedef struct packed {
    logic    take;      // request transfer this cycle
    op_e     op;
    status_e status;
    logic    rd_en;     // read front and back entries
    logic    load_rsp;  // load the result register
  } deq_cmd_t;

  // status from the datapath
  typedef struct packed {
    logic empty;
    logic full;
    logic rsp_free;     // result register can take a new result
  } deq_flags_t;

endpackage

// ----- hw/rtl/deq_if.sv -----
// ----------------------------------------------------------------------------
// deq_req_if / deq_rsp_if
// Valid/ready channels of the double-ended queue: request in, result out.
// ----------------------------------------------------------------------------
interface deq_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic signed [31:0] data_value;

  modport source (output valid, output req_type, output data_value, input ready);
  modport sink   (input valid, input req_type, input data_value, output ready);
endinterface

interface deq_rsp_if #(
  parameter int unsigned CNT_W = 5
);
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               is_empty;
  logic [CNT_W-1:0]   element_count;
  logic signed [31:0] first_value;
  logic signed [31:0] last_value;

  modport source (output valid, output status, output is_empty, output element_count,
                  output first_value, output last_value, input ready);
  modport sink   (input valid, input status, input is_empty, input element_count,
                  input first_value, input last_value, output ready);
endinterface

// ----- hw/rtl/double_ended_queue.sv -----
// Order: a request transfers in the idle state, the entry RAM is read in the read state
// and the result register is loaded in the load state; no new request is taken until
// that load, as set by the registered read of the entry RAM; a stalled result holds the sequencer.
// Reset: front pointer, fill count, sequencer and result valid clear at once;
// the entry RAM is not cleared, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed 32-bit values held in a ring buffer,
// with push and pop at both ends and a status result for every request.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  deq_req_if.sink   req_i,
  deq_rsp_if.source rsp_o
);
  import deq_pkg::*;

  deq_cmd_t   cmd;
  deq_flags_t flags;

  // request sequencer
  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .req_ready_o (req_i.ready),
    .flags_i     (flags),
    .cmd_o       (cmd)
  );

  // ring datapath
  deq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .flags_o         (flags),
    .data_value_i    (req_i.data_value),
    .rsp_valid_o     (rsp_o.valid),
    .rsp_ready_i     (rsp_o.ready),
    .status_o        (rsp_o.status),
    .is_empty_o      (rsp_o.is_empty),
    .element_count_o (rsp_o.element_count),
    .first_value_o   (rsp_o.first_value),
    .last_value_o    (rsp_o.last_value)
  );

endmodule

// ----- hw/rtl/deq_ram.sv -----
// ----------------------------------------------------------------------------
// deq_ram
// Generic RAM, one write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read ports
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ----- hw/rtl/deq_ctrl.sv -----
// ----------------------------------------------------------------------------
// deq_ctrl
// Request sequencer: decodes each request against the full/empty flags and
// steps through transfer, entry read and result load.
// ----------------------------------------------------------------------------
module deq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic [2:0]          req_type_i,
  output logic                req_ready_o,
  input  deq_pkg::deq_flags_t flags_i,
  output deq_pkg::deq_cmd_t   cmd_o
);
  import deq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_LOAD = 3'b100
  } state_e;

  state_e state_q, state_d;

  // request decode
  always_comb begin
    cmd_o        = '0;
    cmd_o.op     = OP_NONE;
    cmd_o.status = STAT_DONE;
    case (req_type_i)
      REQ_PUSH_FRONT: begin
        if (flags_i.full) cmd_o.status = STAT_FULL;
        else              cmd_o.op     = OP_PUSH_FRONT;
      end
      REQ_PUSH_BACK: begin
        if (flags_i.full) cmd_o.status = STAT_FULL;
        else              cmd_o.op     = OP_PUSH_BACK;
      end
      REQ_POP_FRONT: begin
        if (flags_i.empty) cmd_o.status = STAT_EMPTY;
        else               cmd_o.op     = OP_POP_FRONT;
      end
      REQ_POP_BACK: begin
        if (flags_i.empty) cmd_o.status = STAT_EMPTY;
        else               cmd_o.op     = OP_POP_BACK;
      end
      default: begin
        cmd_o.op = OP_NONE;
      end
    endcase

    req_ready_o = 1'b0;
    state_d     = state_q;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.take  = req_valid_i;
        if (req_valid_i) state_d = ST_READ;
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_LOAD;
      end
      ST_LOAD: begin
        if (flags_i.rsp_free) begin
          cmd_o.load_rsp = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hw/rtl/deq_dpath.sv -----
// ----------------------------------------------------------------------------
// deq_dpath
// Ring datapath: front pointer, fill count, entry RAM and result register.
// ----------------------------------------------------------------------------
module deq_dpath #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  deq_pkg::deq_cmd_t             cmd_i,
  output deq_pkg::deq_flags_t           flags_o,
  input  logic signed [31:0]            data_value_i,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output logic [1:0]                    status_o,
  output logic                          is_empty_o,
  output logic [$clog2(DEPTH+1)-1:0]    element_count_o,
  output logic signed [31:0]            first_value_o,
  output logic signed [31:0]            last_value_o
);
  import deq_pkg::*;

  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned SumW  = AddrW + 1;

  logic [AddrW-1:0] front_q, front_d;
  logic [CntW-1:0]  count_q, count_d;
  status_e          status_q;

  logic             rsp_valid_q;
  status_e          rsp_status_q;
  logic [CntW-1:0]  rsp_count_q;
  logic [DataW-1:0] rsp_first_q;
  logic [DataW-1:0] rsp_last_q;

  logic [AddrW-1:0] front_dec;
  logic [AddrW-1:0] front_inc;
  logic [SumW-1:0]  back_sum;
  logic [SumW-1:0]  last_sum;
  logic [AddrW-1:0] back_addr;
  logic [AddrW-1:0] last_addr;
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [DataW-1:0] rdata_a;
  logic [DataW-1:0] rdata_b;
  logic             empty;
  logic             full;

  assign empty = (count_q == '0);
  assign full  = (count_q == CntW'(DEPTH));

  // ring index arithmetic, sums stay below twice the depth
  always_comb begin
    front_dec = (front_q == '0) ? AddrW'(DEPTH - 1) : front_q - 1'b1;
    front_inc = (front_q == AddrW'(DEPTH - 1)) ? '0 : front_q + 1'b1;
    back_sum  = SumW'(front_q) + SumW'(count_q);
    last_sum  = back_sum - 1'b1;
    back_addr = (back_sum >= SumW'(DEPTH)) ? AddrW'(back_sum - SumW'(DEPTH))
                                           : AddrW'(back_sum);
    last_addr = (last_sum >= SumW'(DEPTH)) ? AddrW'(last_sum - SumW'(DEPTH))
                                           : AddrW'(last_sum);
  end

  // pointer and count update on a request transfer
  always_comb begin
    front_d = front_q;
    count_d = count_q;
    we      = 1'b0;
    waddr   = back_addr;
    if (cmd_i.take) begin
      case (cmd_i.op)
        OP_PUSH_FRONT: begin
          front_d = front_dec;
          count_d = count_q + 1'b1;
          we      = 1'b1;
          waddr   = front_dec;
        end
        OP_PUSH_BACK: begin
          count_d = count_q + 1'b1;
          we      = 1'b1;
        end
        OP_POP_FRONT: begin
          front_d = front_inc;
          count_d = count_q - 1'b1;
        end
        OP_POP_BACK: begin
          count_d = count_q - 1'b1;
        end
        default: begin
          front_d = front_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      count_q  <= '0;
      status_q <= STAT_DONE;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      if (cmd_i.take) status_q <= cmd_i.status;
    end
  end

  // entry store
  deq_ram #(
    .WIDTH (DataW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (data_value_i),
    .re_i      (cmd_i.rd_en),
    .raddr_a_i (front_q),
    .raddr_b_i (last_addr),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // result register, freed by a result transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.load_rsp) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_rsp) begin
      rsp_status_q <= status_q;
      rsp_count_q  <= count_q;
      rsp_first_q  <= empty ? '0 : rdata_a;
      rsp_last_q   <= empty ? '0 : rdata_b;
    end
  end

  assign flags_o.empty    = empty;
  assign flags_o.full     = full;
  assign flags_o.rsp_free = !rsp_valid_q || rsp_ready_i;

  assign rsp_valid_o     = rsp_valid_q;
  assign status_o        = rsp_status_q;
  assign is_empty_o      = (rsp_count_q == '0);
  assign element_count_o = rsp_count_q;
  assign first_value_o   = rsp_first_q;
  assign last_value_o    = rsp_last_q;

  // fill count never passes the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("fill count above depth");

  // no push is applied to a full ring
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take && (cmd_i.op == OP_PUSH_FRONT || cmd_i.op == OP_PUSH_BACK) |-> !full)
    else $error("push applied while full");

  // no pop is applied to an empty ring
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take && (cmd_i.op == OP_POP_FRONT || cmd_i.op == OP_POP_BACK) |-> !empty)
    else $error("pop applied while empty");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_rsp |-> (!rsp_valid_q || rsp_ready_i))
    else $error("result overwritten before transfer");

  // a refused request, a query or an unused code leaves the ring as it was
  a_refused_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take && cmd_i.op == OP_NONE |=> $stable(count_q) && $stable(front_q))
    else $error("refused request changed the ring");

endmodule

// ----- bench/tb_double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Self-checking bench for the double-ended queue. A scoreboard keeps its own
// ring of entries, predicts status, fill and end values for every request
// transfer and checks each result transfer in order. Directed requests cover
// empty and full refusals, extreme values and unused codes. Bursts biased
// toward pushes, toward pops or balanced then walk the fill between empty and
// full under three idle patterns on both channels.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
  import deq_pkg::*;

  localparam int unsigned QDepth = 16;
  localparam int unsigned CntW   = 5;

  // one predicted result
  typedef struct {
    status_e            status;
    logic               empty;
    logic [CntW-1:0]    count;
    logic signed [31:0] first;
    logic signed [31:0] last;
  } deq_result_t;

  // ring predictor and ordered store of predicted results
  class deq_scoreboard;
    localparam int unsigned SLOTS = QDepth;
    logic signed [31:0] slot [SLOTS];
    logic [$clog2(SLOTS)-1:0] head;
    int unsigned fill;
    deq_result_t awaited [$];
    int unsigned errors;
    int unsigned n_push, n_pop, n_query, n_full, n_empty, peak_fill;

    function new();
      foreach (slot[i]) slot[i] = '0;
      head = '0;
      fill = 0;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // apply one request transfer to the ring and queue its result
    function void note_request(logic [2:0] code, logic signed [31:0] value);
      deq_result_t r;
      logic [$clog2(SLOTS)-1:0] idx;
      r.status = STAT_DONE;
      case (code)
        REQ_PUSH_FRONT: begin
          n_push++;
          if (fill == SLOTS) begin
            r.status = STAT_FULL;
          end else begin
            head = head - 1'b1;
            slot[head] = value;
            fill++;
          end
        end
        REQ_PUSH_BACK: begin
          n_push++;
          if (fill == SLOTS) begin
            r.status = STAT_FULL;
          end else begin
            idx = head + fill[$clog2(SLOTS)-1:0];
            slot[idx] = value;
            fill++;
          end
        end
        REQ_POP_FRONT: begin
          n_pop++;
          if (fill == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            head = head + 1'b1;
            fill--;
          end
        end
        REQ_POP_BACK: begin
          n_pop++;
          if (fill == 0) r.status = STAT_EMPTY;
          else fill--;
        end
        // query and the unused codes leave the ring alone
        default: n_query++;
      endcase
      if (r.status == STAT_FULL) n_full++;
      if (r.status == STAT_EMPTY) n_empty++;
      if (fill > peak_fill) peak_fill = fill;
      r.empty = (fill == 0);
      r.count = fill[CntW-1:0];
      r.first = '0;
      r.last  = '0;
      if (fill != 0) begin
        idx = head + fill[$clog2(SLOTS)-1:0] - 1'b1;
        r.first = slot[head];
        r.last  = slot[idx];
      end
      awaited.push_back(r);
    endfunction

    // compare one result transfer with the oldest prediction
    task check_result(logic [1:0] status, logic is_empty, logic [CntW-1:0] count,
                      logic signed [31:0] first, logic signed [31:0] last);
      deq_result_t r;
      if (awaited.size() == 0) begin
        report("result transfer with no request outstanding");
      end else begin
        r = awaited.pop_front();
        if (status !== r.status)
          report($sformatf("status %0d, predicted %0d", status, r.status));
        if (is_empty !== r.empty)
          report($sformatf("is_empty %0b, predicted %0b", is_empty, r.empty));
        if (count !== r.count)
          report($sformatf("element_count %0d, predicted %0d", count, r.count));
        if (first !== r.first)
          report($sformatf("first_value %0d, predicted %0d", first, r.first));
        if (last !== r.last)
          report($sformatf("last_value %0d, predicted %0d", last, r.last));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  deq_req_if                  req_if ();
  deq_rsp_if #(.CNT_W(CntW)) rsp_if ();

  deq_scoreboard sb = new();

  double_ended_queue #(
    .DEPTH(QDepth)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // overall time limit
  initial begin
    #8000000;
    $display("timeout waiting for traffic to finish");
    $display("DONE: errors detected");
    $finish;
  end

  // request transfers feed the predictor
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready)
      sb.note_request(req_if.req_type, req_if.data_value);
  end

  // result transfers are checked
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      sb.check_result(rsp_if.status, rsp_if.is_empty, rsp_if.element_count,
                      rsp_if.first_value, rsp_if.last_value);
  end

  // receiver stalls
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // present one request, starting and ending at a falling edge
  task send_request(logic [2:0] code, logic signed [31:0] value);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= code;
    req_if.data_value <= value;
    do begin
      @(posedge clk_i);
      taken = req_if.ready;
      @(negedge clk_i);
    end while (!taken);
  endtask

  // hold off the sender until every result has come back
  task drain_results();
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
  endtask

  // random value with the extremes mixed in
  function logic signed [31:0] pick_value();
    case ($urandom_range(11))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // bursts leaning toward pushes, toward pops or neither so the fill sweeps empty to full
  task run_traffic(int unsigned items);
    int unsigned remaining;
    int unsigned burst;
    int unsigned push_pct;
    logic [2:0] code;
    remaining = items;
    while (remaining > 0) begin
      burst = $urandom_range(40, 6);
      case ($urandom_range(2))
        0:       push_pct = 80;
        1:       push_pct = 20;
        default: push_pct = 50;
      endcase
      for (int i = 0; i < burst && remaining > 0; i++) begin
        if ($urandom_range(99) < 5)
          code = 3'($urandom_range(7, REQ_QUERY));
        else if ($urandom_range(99) < push_pct)
          code = 3'($urandom_range(REQ_PUSH_BACK, REQ_PUSH_FRONT));
        else
          code = 3'($urandom_range(REQ_POP_BACK, REQ_POP_FRONT));
        send_request(code, pick_value());
        remaining--;
      end
    end
  endtask

  // main sequence
  initial begin
    int unsigned wait_cycles;
    req_if.valid      = 1'b0;
    req_if.req_type   = REQ_QUERY;
    req_if.data_value = '0;
    send_idle_pct     = 0;
    recv_idle_pct     = 0;
    rst_ni            = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty refusals and unused codes
    send_request(REQ_QUERY, 32'sd5);
    send_request(REQ_POP_FRONT, 32'sd1);
    send_request(REQ_POP_BACK, 32'sd2);
    send_request(3'd5, 32'sh7fff_ffff);
    send_request(3'd7, 32'sh8000_0000);
    // fill to the top from both ends
    send_request(REQ_PUSH_FRONT, 32'sh8000_0000);
    send_request(REQ_PUSH_BACK, 32'sh7fff_ffff);
    send_request(REQ_PUSH_FRONT, -32'sd1);
    send_request(REQ_PUSH_BACK, 32'sd0);
    for (int i = 4; i < QDepth; i++)
      send_request(i[0] ? REQ_PUSH_BACK : REQ_PUSH_FRONT, $urandom);
    // full refusals at both ends
    send_request(REQ_PUSH_FRONT, 32'sd11);
    send_request(REQ_PUSH_BACK, 32'sd12);
    send_request(3'd6, 32'sd0);
    send_request(REQ_POP_FRONT, 32'sd0);
    send_request(REQ_POP_BACK, 32'sd0);
    drain_results();

    // random traffic under three idle patterns
    send_idle_pct = 22;
    recv_idle_pct = 86;
    run_traffic(480);
    drain_results();
    send_idle_pct = 86;
    recv_idle_pct = 22;
    run_traffic(480);
    drain_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_traffic(490);
    req_if.valid <= 1'b0;

    // let the last results out, then wait and check that none is still awaited
    while (sb.pending() != 0) @(posedge clk_i);
    wait_cycles = 8;
    repeat (wait_cycles) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d predicted results never arrived", sb.pending()));

    $display("covered %0d pushes, %0d pops, %0d queries; %0d full and %0d empty refusals",
             sb.n_push, sb.n_pop, sb.n_query, sb.n_full, sb.n_empty);
    $display("peak fill %0d of %0d entries, %0d mismatches", sb.peak_fill, QDepth,
             sb.errors);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- double_ended_queue.f -----
hw/rtl/deq_pkg.sv
hw/rtl/deq_if.sv
hw/rtl/deq_ram.sv
hw/rtl/deq_ctrl.sv
hw/rtl/deq_dpath.sv
hw/rtl/double_ended_queue.sv
bench/tb_double_ended_queue.sv
